// ===== hdl/eti_pkg.sv =====
`default_nettype none

package eti_pkg;

    // fixed field widths
    localparam int IN_BITS       = 32;
    localparam int COUNT_BITS    = 16;
    localparam int LIMIT_BITS    = 31;
    localparam int CFG_IDX_BITS  = 8;
    localparam int CFG_DATA_BITS = 32;

    // defaults for the top-level parameters
    localparam int FRAC_BITS_DEF = 28;
    localparam int WORD_BITS_DEF = 32;

    // shared multiplier works on 32-bit limbs; words are at most two limbs wide
    localparam int LIMB_BITS     = 32;
    localparam int MAX_LIMBS     = 2;
    localparam int LIMB_IDX_BITS = 1;

    // register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_ITER   = 8'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ESC_LIMIT  = 8'd1;

    localparam logic [COUNT_BITS-1:0] MAX_ITER_RST  = 16'd100;
    localparam logic [LIMIT_BITS-1:0] ESC_LIMIT_RST = 31'h4000_0000;

    // which product the multiplier is building
    typedef logic [1:0] t_prod;
    localparam t_prod PROD_RE2   = 2'd0;
    localparam t_prod PROD_IM2   = 2'd1;
    localparam t_prod PROD_CROSS = 2'd2;

    typedef logic [LIMB_IDX_BITS-1:0] t_limb;

    typedef struct packed {
        logic  load;
        logic  clr;
        logic  mul;
        logic  store;
        logic  upd;
        logic  inc;
        logic  emit;
        t_prod prod;
        t_limb limb_a;
        t_limb limb_b;
    } t_cmd;

    typedef struct packed {
        logic at_limit;
        logic escaped;
        logic out_free;
    } t_stat;

endpackage

`default_nettype wire

// ===== hdl/eti_if.sv =====
`default_nettype none

interface eti_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [eti_pkg::IN_BITS-1:0]  start_re;
    logic signed [eti_pkg::IN_BITS-1:0]  start_im;
    logic signed [eti_pkg::IN_BITS-1:0]  offset_re;
    logic signed [eti_pkg::IN_BITS-1:0]  offset_im;

    modport source (output valid, start_re, start_im, offset_re, offset_im, input ready);
    modport sink   (input valid, start_re, start_im, offset_re, offset_im, output ready);
endinterface

interface eti_out_if;
    logic                                valid;
    logic                                ready;
    logic [eti_pkg::COUNT_BITS-1:0]      step_count;

    modport source (output valid, step_count, input ready);
    modport sink   (input valid, step_count, output ready);
endinterface

interface eti_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [eti_pkg::CFG_IDX_BITS-1:0]    index;
    logic [eti_pkg::CFG_DATA_BITS-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== hdl/eti_dp.sv =====
`default_nettype none

module eti_dp #(
    parameter int FRAC_BITS = eti_pkg::FRAC_BITS_DEF,
    parameter int WORD_BITS = eti_pkg::WORD_BITS_DEF
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire eti_pkg::t_cmd                         i_cmd,
    output eti_pkg::t_stat                             o_stat,
    input  wire logic signed [eti_pkg::IN_BITS-1:0]    i_start_re,
    input  wire logic signed [eti_pkg::IN_BITS-1:0]    i_start_im,
    input  wire logic signed [eti_pkg::IN_BITS-1:0]    i_offset_re,
    input  wire logic signed [eti_pkg::IN_BITS-1:0]    i_offset_im,
    input  wire logic [eti_pkg::COUNT_BITS-1:0]        i_max_iter,
    input  wire logic [eti_pkg::LIMIT_BITS-1:0]        i_esc_limit,
    output logic                                       o_out_valid,
    input  wire logic                                  i_out_ready,
    output logic [eti_pkg::COUNT_BITS-1:0]             o_step_count
);

    localparam int W      = WORD_BITS;
    localparam int LIMBS  = (WORD_BITS + eti_pkg::LIMB_BITS - 1) / eti_pkg::LIMB_BITS;
    localparam int OPW    = eti_pkg::MAX_LIMBS * eti_pkg::LIMB_BITS;
    localparam int ACCW   = 2 * LIMBS * eti_pkg::LIMB_BITS;
    localparam int SQW    = 2 * W;
    localparam int SUMW   = SQW + 1;
    localparam int EXTW   = (W > eti_pkg::IN_BITS) ? W : eti_pkg::IN_BITS;
    localparam int MAGW   = (W > eti_pkg::LIMIT_BITS) ? W : eti_pkg::LIMIT_BITS;
    localparam logic signed [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};

    function automatic logic signed [W-1:0] load_in(input logic signed [eti_pkg::IN_BITS-1:0] v);
        logic signed [EXTW-1:0] e;
        logic [EXTW-W:0]        up;
        e  = EXTW'(v);
        up = e[EXTW-1:W-1];
        if (&up || ~|up) begin
            return e[W-1:0];
        end
        return e[EXTW-1] ? WMIN : WMAX;
    endfunction

    function automatic logic signed [W-1:0] sat_sum(input logic signed [SUMW-1:0] v);
        logic [SUMW-W:0] up;
        up = v[SUMW-1:W-1];
        if (&up || ~|up) begin
            return v[W-1:0];
        end
        return v[SUMW-1] ? WMIN : WMAX;
    endfunction

    // exact magnitude: the most negative word maps to 2^(W-1)
    function automatic logic [W-1:0] mag(input logic signed [W-1:0] v);
        return v[W-1] ? W'(-v) : W'(v);
    endfunction

    logic signed [W-1:0]            r_re, r_im, r_cre, r_cim;
    logic signed [SQW-1:0]          r_sq, r_cr;
    logic [ACCW-1:0]                r_acc;
    logic [eti_pkg::COUNT_BITS-1:0] r_n;
    logic                           r_out_valid;
    logic [eti_pkg::COUNT_BITS-1:0] r_out;

    logic [W-1:0]                        mag_re, mag_im, op_a, op_b;
    logic [OPW-1:0]                      a_ext, b_ext;
    logic [eti_pkg::LIMB_BITS-1:0]       limb_a, limb_b;
    logic [2*eti_pkg::LIMB_BITS-1:0]     pp;
    logic [eti_pkg::LIMB_IDX_BITS:0]     limb_pos;
    logic [ACCW-1:0]                     n_acc;
    logic signed [SQW-1:0]               prod_val;
    logic signed [SQW-1:0]               sh_re, sh_im;
    logic signed [SUMW-1:0]              sum_re, sum_im;
    logic [MAGW-1:0]                     esc_re, esc_im, esc_lim;

    always_comb begin
        mag_re = mag(r_re);
        mag_im = mag(r_im);
        op_a   = (i_cmd.prod == eti_pkg::PROD_IM2) ? mag_im : mag_re;
        op_b   = (i_cmd.prod == eti_pkg::PROD_RE2) ? mag_re : mag_im;
        a_ext  = OPW'(op_a);
        b_ext  = OPW'(op_b);
        limb_a = a_ext[eti_pkg::LIMB_BITS*i_cmd.limb_a +: eti_pkg::LIMB_BITS];
        limb_b = b_ext[eti_pkg::LIMB_BITS*i_cmd.limb_b +: eti_pkg::LIMB_BITS];
        pp     = limb_a * limb_b;
        limb_pos = {1'b0, i_cmd.limb_a} + {1'b0, i_cmd.limb_b};
        n_acc  = r_acc + (ACCW'(pp) << (eti_pkg::LIMB_BITS * int'(limb_pos)));
        prod_val = signed'(r_acc[SQW-1:0]);

        sh_re  = r_sq >>> FRAC_BITS;
        sh_im  = r_cr >>> (FRAC_BITS - 1);
        sum_re = SUMW'(sh_re) + SUMW'(r_cre);
        sum_im = SUMW'(sh_im) + SUMW'(r_cim);

        esc_re  = MAGW'(mag_re);
        esc_im  = MAGW'(mag_im);
        esc_lim = MAGW'(i_esc_limit);
    end

    assign o_stat.at_limit = (r_n == i_max_iter);
    assign o_stat.escaped  = (esc_re > esc_lim) || (esc_im > esc_lim);
    assign o_stat.out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_re  <= load_in(i_start_re);
            r_im  <= load_in(i_start_im);
            r_cre <= load_in(i_offset_re);
            r_cim <= load_in(i_offset_im);
        end else if (i_cmd.upd) begin
            r_re <= sat_sum(sum_re);
            r_im <= sat_sum(sum_im);
        end

        if (i_cmd.clr) begin
            r_acc <= '0;
        end else if (i_cmd.mul) begin
            r_acc <= n_acc;
        end

        if (i_cmd.store) begin
            case (i_cmd.prod)
                eti_pkg::PROD_RE2:   r_sq <= prod_val;
                eti_pkg::PROD_IM2:   r_sq <= r_sq - prod_val;
                eti_pkg::PROD_CROSS: r_cr <= (r_re[W-1] ^ r_im[W-1]) ? -prod_val : prod_val;
                default:             r_cr <= r_cr;
            endcase
        end

        if (i_cmd.emit) begin
            r_out <= r_n;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_n <= '0;
            end else if (i_cmd.inc) begin
                r_n <= r_n + 1'b1;
            end

            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_step_count = r_out;

endmodule

`default_nettype wire

// ===== hdl/eti_ctrl.sv =====
`default_nettype none

module eti_ctrl #(
    parameter int WORD_BITS = eti_pkg::WORD_BITS_DEF
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    input  wire eti_pkg::t_stat  i_stat,
    output eti_pkg::t_cmd        o_cmd
);

    localparam int LIMBS = (WORD_BITS + eti_pkg::LIMB_BITS - 1) / eti_pkg::LIMB_BITS;
    localparam eti_pkg::t_limb LAST_LIMB = eti_pkg::LIMB_IDX_BITS'(LIMBS - 1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_TEST  = 3'd1;
    localparam logic [2:0] ST_MUL   = 3'd2;
    localparam logic [2:0] ST_STORE = 3'd3;
    localparam logic [2:0] ST_UPD   = 3'd4;
    localparam logic [2:0] ST_CHK   = 3'd5;
    localparam logic [2:0] ST_DONE  = 3'd6;

    logic [2:0]      r_state, n_state;
    eti_pkg::t_prod  r_prod, n_prod;
    eti_pkg::t_limb  r_la, n_la, r_lb, n_lb;

    always_comb begin
        n_state    = r_state;
        n_prod     = r_prod;
        n_la       = r_la;
        n_lb       = r_lb;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_TEST;
                end
            end
            ST_TEST: begin
                if (i_stat.at_limit) begin
                    n_state = ST_DONE;
                end else begin
                    o_cmd.clr = 1'b1;
                    n_prod    = eti_pkg::PROD_RE2;
                    n_la      = '0;
                    n_lb      = '0;
                    n_state   = ST_MUL;
                end
            end
            ST_MUL: begin
                // one limb pair per cycle into the accumulator
                o_cmd.mul    = 1'b1;
                o_cmd.prod   = r_prod;
                o_cmd.limb_a = r_la;
                o_cmd.limb_b = r_lb;
                if (r_lb == LAST_LIMB) begin
                    n_lb = '0;
                    if (r_la == LAST_LIMB) begin
                        n_la    = '0;
                        n_state = ST_STORE;
                    end else begin
                        n_la = r_la + 1'b1;
                    end
                end else begin
                    n_lb = r_lb + 1'b1;
                end
            end
            ST_STORE: begin
                o_cmd.store = 1'b1;
                o_cmd.clr   = 1'b1;
                o_cmd.prod  = r_prod;
                case (r_prod)
                    eti_pkg::PROD_RE2: begin
                        n_prod  = eti_pkg::PROD_IM2;
                        n_state = ST_MUL;
                    end
                    eti_pkg::PROD_IM2: begin
                        n_prod  = eti_pkg::PROD_CROSS;
                        n_state = ST_MUL;
                    end
                    default: begin
                        n_state = ST_UPD;
                    end
                endcase
            end
            ST_UPD: begin
                o_cmd.upd = 1'b1;
                n_state   = ST_CHK;
            end
            ST_CHK: begin
                if (i_stat.escaped) begin
                    n_state = ST_DONE;
                end else begin
                    o_cmd.inc = 1'b1;
                    n_state   = ST_TEST;
                end
            end
            ST_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_prod  <= eti_pkg::PROD_RE2;
            r_la    <= '0;
            r_lb    <= '0;
        end else begin
            r_state <= n_state;
            r_prod  <= n_prod;
            r_la    <= n_la;
            r_lb    <= n_lb;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/escape_time_iteration.sv =====
// Channel   Dir  Word                                          Handshake
// i_in      in   start_re, start_im, offset_re, offset_im     valid/ready
// o_out     out  step_count                                    valid/ready
// i_cfg     in   index, data (0 max_iterations, 1 escape_limit) valid/ready, always ready
//
// One point at a time. Each step runs three products through one shared
// 32x32 multiplier, L*L limb passes each (L = ceil(WORD_BITS/32)). A finished
// point waits in DONE while the output register still holds an unread result;
// that register lets the next word in while a result waits.
// Synchronous active-low reset restores max_iterations = 100, escape_limit = 4.0.
`default_nettype none

module escape_time_iteration #(
    parameter int FRAC_BITS = eti_pkg::FRAC_BITS_DEF,
    parameter int WORD_BITS = eti_pkg::WORD_BITS_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    eti_in_if.sink     i_in,
    eti_out_if.source  o_out,
    eti_cfg_if.sink    i_cfg
);

    logic [eti_pkg::COUNT_BITS-1:0] r_max_iter;
    logic [eti_pkg::LIMIT_BITS-1:0] r_esc_limit;
    eti_pkg::t_cmd                  cmd;
    eti_pkg::t_stat                 stat;
    logic                           in_ready;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_iter  <= eti_pkg::MAX_ITER_RST;
            r_esc_limit <= eti_pkg::ESC_LIMIT_RST;
        end else if (i_cfg.valid) begin
            // unknown indexes are dropped
            case (i_cfg.index)
                eti_pkg::CFG_MAX_ITER:  r_max_iter  <= i_cfg.data[eti_pkg::COUNT_BITS-1:0];
                eti_pkg::CFG_ESC_LIMIT: r_esc_limit <= i_cfg.data[eti_pkg::LIMIT_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    eti_ctrl #(
        .WORD_BITS (WORD_BITS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    assign i_in.ready = in_ready;

    eti_dp #(
        .FRAC_BITS (FRAC_BITS),
        .WORD_BITS (WORD_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_start_re   (i_in.start_re),
        .i_start_im   (i_in.start_im),
        .i_offset_re  (i_in.offset_re),
        .i_offset_im  (i_in.offset_im),
        .i_max_iter   (r_max_iter),
        .i_esc_limit  (r_esc_limit),
        .o_out_valid  (o_out.valid),
        .i_out_ready  (o_out.ready),
        .o_step_count (o_out.step_count)
    );

endmodule

`default_nettype wire
